FILE: rtl/core/bwt_inverse_core_macros.svh
// Assertion macros shared by the inverse Burrows-Wheeler transform RTL.
`ifndef BWT_INVERSE_CORE_MACROS_SVH
`define BWT_INVERSE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BWTI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BWTI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/bwti_pkg.sv
// Constants and types for the inverse Burrows-Wheeler transform core.
`timescale 1ns / 1ps

package bwti_pkg;

    localparam int MAX_LEN  = 4096;
    localparam int ADDR_W   = $clog2(MAX_LEN);
    localparam int CNT_W    = $clog2(MAX_LEN + 1);
    localparam int SYM_W    = 8;
    localparam int NUM_SYM  = 1 << SYM_W;

    typedef enum logic [2:0] {
        PH_LOADING = 3'b001,
        PH_READING = 3'b010,
        PH_DONE    = 3'b100
    } phase_t;

    typedef enum logic [8:0] {
        ST_IDLE       = 9'b000000001,
        ST_LD_CNT     = 9'b000000010,
        ST_SCAN_ISSUE = 9'b000000100,
        ST_SCAN       = 9'b000001000,
        ST_PLACE      = 9'b000010000,
        ST_START      = 9'b000100000,
        ST_LOAD_PTR   = 9'b001000000,
        ST_RD_IDX     = 9'b010000000,
        ST_RD_SYM     = 9'b100000000
    } state_t;

endpackage

FILE: rtl/core/bwt_inverse_core.sv
// Inverse Burrows-Wheeler transform core: block load, counting sort and forward walk.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------------
//  cmd     | cmd_valid, cmd_ready | kind, symbol, last
//  res     | res_valid, res_ready | text_byte, end_of_text, past_end, overflowed
//
// A load item writes its symbol and reads its count in ST_IDLE, then writes the count
// back in ST_LD_CNT; a load beyond capacity only sets the overflow flag. A read item
// reads the sorted index memory in ST_IDLE and the symbol memory in ST_RD_IDX; a read
// past the end skips both. Closing a block runs prefix sum, placement and pointer load.
// Reset clears all control state at once; the stores need no clearing pass.
// A stalled result register holds the next read item in ST_RD_SYM; loads go in until then.
`timescale 1ns / 1ps

module bwt_inverse_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  logic                        kind,
    input  logic [bwti_pkg::SYM_W-1:0]  symbol,
    input  logic                        last,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic [bwti_pkg::SYM_W-1:0]  text_byte,
    output logic                        end_of_text,
    output logic                        past_end,
    output logic                        overflowed
);

    localparam int AW = bwti_pkg::ADDR_W;
    localparam int CW = bwti_pkg::CNT_W;
    localparam int SW = bwti_pkg::SYM_W;
    localparam logic [SW-1:0] LAST_SYM = SW'(bwti_pkg::NUM_SYM - 1);

    bwti_pkg::state_t state_reg, state_next;
    bwti_pkg::phase_t phase_reg, phase_next;

    logic [CW-1:0]                   len_reg, len_next;
    logic [CW-1:0]                   emitted_reg, emitted_next;
    logic [AW-1:0]                   walk_reg, walk_next;
    logic                            ovf_reg, ovf_next;
    logic [bwti_pkg::NUM_SYM-1:0]    cnt_valid_reg, cnt_valid_next;
    logic [SW-1:0]                   idx_reg, idx_next;
    logic [CW-1:0]                   sum_reg, sum_next;
    logic [CW-1:0]                   pi_reg, pi_next;
    logic                            v1_reg, v1_next;
    logic                            v2_reg, v2_next;
    logic                            fw_valid_reg, fw_valid_next;
    logic                            out_valid_reg, out_valid_next;

    logic [SW-1:0]                   ld_sym_reg, ld_sym_next;
    logic                            ld_last_reg, ld_last_next;
    logic [AW-1:0]                   i1_reg, i1_next;
    logic [AW-1:0]                   i2_reg, i2_next;
    logic [SW-1:0]                   s2_reg, s2_next;
    logic [SW-1:0]                   fw_sym_reg, fw_sym_next;
    logic [CW-1:0]                   fw_val_reg, fw_val_next;
    logic                            eot_reg, eot_next;
    logic                            pe_reg, pe_next;
    logic [SW-1:0]                   text_reg, text_next;
    logic                            end_reg, end_next;
    logic                            pend_reg, pend_next;
    logic                            oflow_reg, oflow_next;

    logic [SW-1:0] sym_mem [bwti_pkg::MAX_LEN];
    logic          sym_we, sym_re;
    logic [AW-1:0] sym_waddr, sym_raddr;
    logic [SW-1:0] sym_wdata, sym_rdata_reg;

    logic [AW-1:0] srt_mem [bwti_pkg::MAX_LEN];
    logic          srt_we, srt_re;
    logic [AW-1:0] srt_waddr, srt_raddr, srt_wdata, srt_rdata_reg;

    logic [CW-1:0] cnt_mem [bwti_pkg::NUM_SYM];
    logic          cnt_we, cnt_re;
    logic [SW-1:0] cnt_waddr, cnt_raddr;
    logic [CW-1:0] cnt_wdata, cnt_rdata_reg;
    logic          cnt_rvalid_reg;

    logic          new_blk;
    logic [CW-1:0] len_cur;
    logic [CW-1:0] cnt_cur;
    logic [CW-1:0] place_dst;

    assign cmd_ready   = (state_reg == bwti_pkg::ST_IDLE);
    assign res_valid   = out_valid_reg;
    assign text_byte   = text_reg;
    assign end_of_text = end_reg;
    assign past_end    = pend_reg;
    assign overflowed  = oflow_reg;

    assign new_blk   = (phase_reg != bwti_pkg::PH_LOADING);
    assign len_cur   = new_blk ? '0 : len_reg;
    assign cnt_cur   = cnt_rvalid_reg ? cnt_rdata_reg : '0;
    assign place_dst = (fw_valid_reg && (fw_sym_reg == s2_reg)) ? fw_val_reg : cnt_rdata_reg;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        len_next       = len_reg;
        emitted_next   = emitted_reg;
        walk_next      = walk_reg;
        ovf_next       = ovf_reg;
        cnt_valid_next = cnt_valid_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        pi_next        = pi_reg;
        v1_next        = v1_reg;
        v2_next        = v2_reg;
        fw_valid_next  = fw_valid_reg;
        out_valid_next = out_valid_reg;
        ld_sym_next    = ld_sym_reg;
        ld_last_next   = ld_last_reg;
        i1_next        = i1_reg;
        i2_next        = i2_reg;
        s2_next        = s2_reg;
        fw_sym_next    = fw_sym_reg;
        fw_val_next    = fw_val_reg;
        eot_next       = eot_reg;
        pe_next        = pe_reg;
        text_next      = text_reg;
        end_next       = end_reg;
        pend_next      = pend_reg;
        oflow_next     = oflow_reg;

        sym_we    = 1'b0;
        sym_waddr = '0;
        sym_wdata = symbol;
        sym_re    = 1'b0;
        sym_raddr = '0;
        srt_we    = 1'b0;
        srt_waddr = '0;
        srt_wdata = '0;
        srt_re    = 1'b0;
        srt_raddr = '0;
        cnt_we    = 1'b0;
        cnt_waddr = '0;
        cnt_wdata = '0;
        cnt_re    = 1'b0;
        cnt_raddr = '0;

        if (out_valid_reg && res_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            bwti_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (!kind)
                    begin
                        if (new_blk)
                        begin
                            cnt_valid_next = '0;
                            emitted_next   = '0;
                            walk_next      = '0;
                            ovf_next       = 1'b0;
                            phase_next     = bwti_pkg::PH_LOADING;
                        end
                        if (len_cur < CW'(bwti_pkg::MAX_LEN))
                        begin
                            sym_we       = 1'b1;
                            sym_waddr    = len_cur[AW-1:0];
                            sym_wdata    = symbol;
                            cnt_re       = 1'b1;
                            cnt_raddr    = symbol;
                            len_next     = len_cur + CW'(1);
                            ld_sym_next  = symbol;
                            ld_last_next = last;
                            state_next   = bwti_pkg::ST_LD_CNT;
                        end
                        else
                        begin
                            len_next = len_cur;
                            ovf_next = 1'b1;
                            if (last)
                            begin
                                state_next = bwti_pkg::ST_SCAN_ISSUE;
                            end
                        end
                    end
                    else if ((phase_reg == bwti_pkg::PH_READING) && (emitted_reg < len_reg))
                    begin
                        srt_re       = 1'b1;
                        srt_raddr    = walk_reg;
                        emitted_next = emitted_reg + CW'(1);
                        eot_next     = ((emitted_reg + CW'(1)) == len_reg);
                        pe_next      = 1'b0;
                        if ((emitted_reg + CW'(1)) == len_reg)
                        begin
                            phase_next = bwti_pkg::PH_DONE;
                        end
                        state_next   = bwti_pkg::ST_RD_IDX;
                    end
                    else
                    begin
                        eot_next   = 1'b0;
                        pe_next    = 1'b1;
                        state_next = bwti_pkg::ST_RD_SYM;
                    end
                end
            end

            bwti_pkg::ST_LD_CNT:
            begin
                cnt_we                     = 1'b1;
                cnt_waddr                  = ld_sym_reg;
                cnt_wdata                  = cnt_cur + CW'(1);
                cnt_valid_next[ld_sym_reg] = 1'b1;
                state_next = ld_last_reg ? bwti_pkg::ST_SCAN_ISSUE : bwti_pkg::ST_IDLE;
            end

            bwti_pkg::ST_SCAN_ISSUE:
            begin
                cnt_re     = 1'b1;
                cnt_raddr  = '0;
                idx_next   = '0;
                sum_next   = '0;
                state_next = bwti_pkg::ST_SCAN;
            end

            bwti_pkg::ST_SCAN:
            begin
                cnt_we                  = 1'b1;
                cnt_waddr               = idx_reg;
                cnt_wdata               = sum_reg;
                cnt_valid_next[idx_reg] = 1'b1;
                sum_next                = sum_reg + cnt_cur;
                if (idx_reg == LAST_SYM)
                begin
                    pi_next       = '0;
                    v1_next       = 1'b0;
                    v2_next       = 1'b0;
                    fw_valid_next = 1'b0;
                    state_next    = bwti_pkg::ST_PLACE;
                end
                else
                begin
                    cnt_re    = 1'b1;
                    cnt_raddr = idx_reg + SW'(1);
                    idx_next  = idx_reg + SW'(1);
                end
            end

            bwti_pkg::ST_PLACE:
            begin
                if (pi_reg < len_reg)
                begin
                    sym_re    = 1'b1;
                    sym_raddr = pi_reg[AW-1:0];
                    pi_next   = pi_reg + CW'(1);
                    v1_next   = 1'b1;
                    i1_next   = pi_reg[AW-1:0];
                end
                else
                begin
                    v1_next = 1'b0;
                end

                if (v1_reg)
                begin
                    cnt_re    = 1'b1;
                    cnt_raddr = sym_rdata_reg;
                    v2_next   = 1'b1;
                    i2_next   = i1_reg;
                    s2_next   = sym_rdata_reg;
                end
                else
                begin
                    v2_next = 1'b0;
                end

                // Same symbol twice in a row: the count read missed the write just made.
                if (v2_reg)
                begin
                    srt_we        = 1'b1;
                    srt_waddr     = place_dst[AW-1:0];
                    srt_wdata     = i2_reg;
                    cnt_we        = 1'b1;
                    cnt_waddr     = s2_reg;
                    cnt_wdata     = place_dst + CW'(1);
                    fw_valid_next = 1'b1;
                    fw_sym_next   = s2_reg;
                    fw_val_next   = place_dst + CW'(1);
                end
                else
                begin
                    fw_valid_next = 1'b0;
                end

                if ((pi_reg >= len_reg) && !v1_reg && !v2_reg)
                begin
                    state_next = bwti_pkg::ST_START;
                end
            end

            bwti_pkg::ST_START:
            begin
                srt_re     = 1'b1;
                srt_raddr  = '0;
                state_next = bwti_pkg::ST_LOAD_PTR;
            end

            bwti_pkg::ST_LOAD_PTR:
            begin
                emitted_next = '0;
                if (len_reg == '0)
                begin
                    walk_next  = '0;
                    phase_next = bwti_pkg::PH_DONE;
                end
                else
                begin
                    walk_next  = srt_rdata_reg;
                    phase_next = bwti_pkg::PH_READING;
                end
                state_next = bwti_pkg::ST_IDLE;
            end

            bwti_pkg::ST_RD_IDX:
            begin
                walk_next  = srt_rdata_reg;
                sym_re     = 1'b1;
                sym_raddr  = srt_rdata_reg;
                state_next = bwti_pkg::ST_RD_SYM;
            end

            bwti_pkg::ST_RD_SYM:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_valid_next = 1'b1;
                    text_next      = pe_reg ? '0 : sym_rdata_reg;
                    end_next       = eot_reg;
                    pend_next      = pe_reg;
                    oflow_next     = ovf_reg;
                    state_next     = bwti_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bwti_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bwti_pkg::ST_IDLE;
            phase_reg     <= bwti_pkg::PH_LOADING;
            len_reg       <= '0;
            emitted_reg   <= '0;
            walk_reg      <= '0;
            ovf_reg       <= 1'b0;
            cnt_valid_reg <= '0;
            idx_reg       <= '0;
            sum_reg       <= '0;
            pi_reg        <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            fw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            emitted_reg   <= emitted_next;
            walk_reg      <= walk_next;
            ovf_reg       <= ovf_next;
            cnt_valid_reg <= cnt_valid_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            pi_reg        <= pi_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            fw_valid_reg  <= fw_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ld_sym_reg  <= ld_sym_next;
        ld_last_reg <= ld_last_next;
        i1_reg      <= i1_next;
        i2_reg      <= i2_next;
        s2_reg      <= s2_next;
        fw_sym_reg  <= fw_sym_next;
        fw_val_reg  <= fw_val_next;
        eot_reg     <= eot_next;
        pe_reg      <= pe_next;
        text_reg    <= text_next;
        end_reg     <= end_next;
        pend_reg    <= pend_next;
        oflow_reg   <= oflow_next;
    end

    always_ff @(posedge clk)
    begin
        if (sym_we)
        begin
            sym_mem[sym_waddr] <= sym_wdata;
        end
        if (sym_re)
        begin
            sym_rdata_reg <= sym_mem[sym_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (srt_we)
        begin
            srt_mem[srt_waddr] <= srt_wdata;
        end
        if (srt_re)
        begin
            srt_rdata_reg <= srt_mem[srt_raddr];
        end
    end

    // The valid bit is taken after any clearing for a new block made in the same cycle.
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_rdata_reg  <= cnt_mem[cnt_raddr];
            cnt_rvalid_reg <= cnt_valid_next[cnt_raddr];
        end
    end

`include "bwt_inverse_core_macros.svh"

    `BWTI_ASSERT_NOW(a_emit_bound, 1'b1, emitted_reg <= len_reg, "Emitted count exceeds the block length.")
    `BWTI_ASSERT_NOW(a_past_end_blank, res_valid && past_end, (text_byte == '0) && !end_of_text, "A past-end result carries a byte or an end mark.")
    `BWTI_ASSERT_NOW(a_scan_total, (state_reg == bwti_pkg::ST_SCAN) && (idx_reg == LAST_SYM), (sum_reg + cnt_cur) == len_reg, "Symbol counts do not add up to the block length.")
    `BWTI_ASSERT_NOW(a_place_dst, (state_reg == bwti_pkg::ST_PLACE) && v2_reg, place_dst < len_reg, "Sorted position lies outside the block.")
    `BWTI_ASSERT_NEXT(a_ptr_phase, state_reg == bwti_pkg::ST_LOAD_PTR, phase_reg != bwti_pkg::PH_LOADING, "Closing a block left the core in the loading phase.")

endmodule

FILE: bench/tb_bwt_inverse_core.sv
// Self-checking testbench for the inverse Burrows-Wheeler transform core.
`timescale 1ns / 1ps

module tb_bwt_inverse_core;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_READ = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        logic [bwti_pkg::SYM_W-1:0] text;
        logic                       eot;
        logic                       pe;
        logic                       ovf;
    } text_result_t;

    typedef struct packed {
        cmd_kind_t                  kind;
        logic [bwti_pkg::SYM_W-1:0] sym;
        logic                       last;
        bit                         typed;
        logic [bwti_pkg::SYM_W-1:0] w_text;
        logic                       w_eot;
        logic                       w_pe;
        logic                       w_ovf;
    } script_row_t;

    localparam int NUM_ROWS     = 25;
    localparam int RANDOM_ITEMS = 700;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cmd_valid = 1'b0;
    logic                       cmd_ready;
    logic                       kind = 1'b0;
    logic [bwti_pkg::SYM_W-1:0] symbol = '0;
    logic                       last = 1'b0;
    logic                       res_valid;
    logic                       res_ready = 1'b0;
    logic [bwti_pkg::SYM_W-1:0] text_byte;
    logic                       end_of_text;
    logic                       past_end;
    logic                       overflowed;

    // Predictor state.
    logic [bwti_pkg::SYM_W-1:0]  blk_sym   [bwti_pkg::MAX_LEN];
    logic [bwti_pkg::ADDR_W-1:0] blk_rank  [bwti_pkg::MAX_LEN];
    logic [bwti_pkg::CNT_W-1:0]  sym_count [bwti_pkg::NUM_SYM];
    logic [bwti_pkg::CNT_W-1:0]  blk_len;
    logic [bwti_pkg::ADDR_W-1:0] walk_pos;
    logic [bwti_pkg::CNT_W-1:0]  emitted;
    bwti_pkg::phase_t            walk_phase;
    logic                        lost_loads;

    text_result_t pending_text [$];
    int           mismatches = 0;

    script_row_t directed_rows [NUM_ROWS] = '{
        '{CMD_READ, 8'h5A, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0},
        '{CMD_LOAD, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CMD_READ, 8'hA5, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0},
        '{CMD_LOAD, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD, 8'h80, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CMD_READ, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CMD_READ, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CMD_READ, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CMD_READ, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0},
        '{CMD_LOAD, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CMD_READ, 8'hFF, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0},
        '{CMD_READ, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0},
        '{CMD_LOAD, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CMD_READ, 8'h00, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0},
        '{CMD_LOAD, 8'h41, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD, 8'h41, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD, 8'h41, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CMD_READ, 8'h3C, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CMD_READ, 8'hC3, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD, 8'h7F, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD, 8'h7F, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CMD_READ, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CMD_READ, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CMD_READ, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}
    };

    bwt_inverse_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .kind        (kind),
        .symbol      (symbol),
        .last        (last),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .past_end    (past_end),
        .overflowed  (overflowed)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL bwt_inverse_core");
        $finish;
    end

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Stable counting sort of the loaded block; the walk starts at the smallest symbol.
    function automatic void sort_block();
        int start [bwti_pkg::NUM_SYM];
        int sum;
        int s;
        sum = 0;
        for (int v = 0; v < bwti_pkg::NUM_SYM; v++)
        begin
            start[v] = sum;
            sum += int'(sym_count[v]);
        end
        for (int i = 0; i < int'(blk_len); i++)
        begin
            s = int'(blk_sym[i]);
            blk_rank[start[s]] = bwti_pkg::ADDR_W'(i);
            start[s]++;
        end
        emitted = '0;
        if (blk_len == '0)
        begin
            walk_pos   = '0;
            walk_phase = bwti_pkg::PH_DONE;
        end
        else
        begin
            walk_pos   = blk_rank[0];
            walk_phase = bwti_pkg::PH_READING;
        end
    endfunction

    function automatic bit recover_text_step(input cmd_kind_t k,
                                             input logic [bwti_pkg::SYM_W-1:0] s,
                                             input logic l, output text_result_t r);
        logic [bwti_pkg::ADDR_W-1:0] nxt;
        r = '0;
        if (k == CMD_LOAD)
        begin
            if (walk_phase != bwti_pkg::PH_LOADING)
            begin
                for (int v = 0; v < bwti_pkg::NUM_SYM; v++)
                begin
                    sym_count[v] = '0;
                end
                blk_len    = '0;
                walk_pos   = '0;
                emitted    = '0;
                lost_loads = 1'b0;
                walk_phase = bwti_pkg::PH_LOADING;
            end
            if (int'(blk_len) < bwti_pkg::MAX_LEN)
            begin
                blk_sym[blk_len[bwti_pkg::ADDR_W-1:0]] = s;
                sym_count[s] = sym_count[s] + bwti_pkg::CNT_W'(1);
                blk_len = blk_len + bwti_pkg::CNT_W'(1);
            end
            else
            begin
                lost_loads = 1'b1;
            end
            if (l)
            begin
                sort_block();
            end
            return 1'b0;
        end
        r.ovf = lost_loads;
        if (walk_phase != bwti_pkg::PH_READING || emitted >= blk_len)
        begin
            r.pe = 1'b1;
            return 1'b1;
        end
        nxt      = blk_rank[walk_pos];
        r.text   = blk_sym[nxt];
        walk_pos = nxt;
        emitted  = emitted + bwti_pkg::CNT_W'(1);
        if (emitted == blk_len)
        begin
            r.eot      = 1'b1;
            walk_phase = bwti_pkg::PH_DONE;
        end
        return 1'b1;
    endfunction

    task automatic push_cmd(input cmd_kind_t k, input logic [bwti_pkg::SYM_W-1:0] s,
                            input logic l, input bit typed, input text_result_t want,
                            input int gap);
        text_result_t predicted;
        @(negedge clk);
        cmd_valid <= 1'b1;
        kind      <= k;
        symbol    <= s;
        last      <= l;
        do
        begin
            @(posedge clk);
        end
        while (!cmd_ready);
        if (recover_text_step(k, s, l, predicted))
        begin
            pending_text.push_back(typed ? want : predicted);
        end
        repeat (gap)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
        end
    endtask

    task automatic report_mismatch(input string why, input text_result_t want,
                                   input text_result_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch at %0t (%s): expected text %02h eot %0b past %0b ovf %0b",
                     $realtime, why, want.text, want.eot, want.pe, want.ovf);
            $display("    got text %02h eot %0b past %0b ovf %0b",
                     got.text, got.eot, got.pe, got.ovf);
        end
    endtask

    always @(posedge clk)
    begin
        text_result_t want;
        text_result_t got;
        if (rst_n && res_valid && res_ready)
        begin
            got.text = text_byte;
            got.eot  = end_of_text;
            got.pe   = past_end;
            got.ovf  = overflowed;
            if (pending_text.size() == 0)
            begin
                report_mismatch("no item expected", '0, got);
            end
            else
            begin
                want = pending_text.pop_front();
                if (got.text !== want.text || got.eot !== want.eot ||
                    got.pe !== want.pe || got.ovf !== want.ovf)
                begin
                    report_mismatch("field differs", want, got);
                end
            end
        end
    end

    initial
    begin
        int n;
        int g;
        @(posedge rst_n);
        forever
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
            repeat (n)
            begin
                @(negedge clk);
                res_ready <= 1'b1;
            end
            g = pick_gap(1'b0);
            if (g == 0)
            begin
                g = 1;
            end
            repeat (g)
            begin
                @(negedge clk);
                res_ready <= 1'b0;
            end
        end
    end

    initial
    begin
        script_row_t                row;
        text_result_t               want;
        int                         sent;
        int                         len;
        int                         reads;
        int                         r;
        bit                         calm;
        bit                         narrow;
        bit                         first;
        logic [bwti_pkg::SYM_W-1:0] base;
        logic [bwti_pkg::SYM_W-1:0] s;

        for (int v = 0; v < bwti_pkg::NUM_SYM; v++)
        begin
            sym_count[v] = '0;
        end
        blk_len    = '0;
        walk_pos   = '0;
        emitted    = '0;
        lost_loads = 1'b0;
        walk_phase = bwti_pkg::PH_LOADING;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            row  = directed_rows[i];
            want = '{row.w_text, row.w_eot, row.w_pe, row.w_ovf};
            push_cmd(row.kind, row.sym, row.last, row.typed, want, pick_gap(1'b0));
        end

        // A block of exactly full capacity, walked to the end and one past it.
        for (int i = 0; i < bwti_pkg::MAX_LEN; i++)
        begin
            s = bwti_pkg::SYM_W'($urandom);
            push_cmd(CMD_LOAD, s, i == bwti_pkg::MAX_LEN - 1, 1'b0, '0, 0);
        end
        for (int i = 0; i <= bwti_pkg::MAX_LEN; i++)
        begin
            s = bwti_pkg::SYM_W'($urandom);
            push_cmd(CMD_READ, s, 1'($urandom_range(0, 1)), 1'b0, '0, 0);
        end

        // An overfull block: the surplus loads are dropped, the final one still closes it.
        for (int i = 0; i < bwti_pkg::MAX_LEN + 3; i++)
        begin
            s = bwti_pkg::SYM_W'($urandom_range(0, 3));
            push_cmd(CMD_LOAD, s, i == bwti_pkg::MAX_LEN + 2, 1'b0, '0, 0);
        end
        for (int i = 0; i < 30; i++)
        begin
            s = bwti_pkg::SYM_W'($urandom);
            push_cmd(CMD_READ, s, 1'($urandom_range(0, 1)), 1'b0, '0, pick_gap(1'b0));
        end

        sent  = 0;
        first = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            if (first || $urandom_range(0, 9) == 0)
            begin
                @(negedge clk);
                cmd_valid <= 1'b0;
                while (pending_text.size() != 0) @(posedge clk);
            end
            first  = 1'b0;
            calm   = ($urandom_range(0, 4) == 0);
            narrow = ($urandom_range(0, 2) == 0);
            base   = bwti_pkg::SYM_W'($urandom);
            r      = $urandom_range(0, 99);
            if (r < 70)
            begin
                len = $urandom_range(1, 8);
            end
            else if (r < 92)
            begin
                len = $urandom_range(9, 40);
            end
            else
            begin
                len = $urandom_range(41, 300);
            end
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    s = bwti_pkg::SYM_W'($urandom);
                    push_cmd(CMD_READ, s, 1'($urandom_range(0, 1)), 1'b0, '0, pick_gap(calm));
                    sent++;
                end
                s = narrow ? bwti_pkg::SYM_W'(base + $urandom_range(0, 3))
                           : bwti_pkg::SYM_W'($urandom);
                push_cmd(CMD_LOAD, s, i == len - 1, 1'b0, '0, pick_gap(calm));
                sent++;
            end
            if ($urandom_range(0, 6) == 0)
            begin
                reads = $urandom_range(1, len);
            end
            else
            begin
                reads = len + $urandom_range(0, 2);
            end
            for (int i = 0; i < reads; i++)
            begin
                s = bwti_pkg::SYM_W'($urandom);
                push_cmd(CMD_READ, s, 1'($urandom_range(0, 1)), 1'b0, '0, pick_gap(calm));
                sent++;
            end
        end

        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_text.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && pending_text.size() == 0)
        begin
            $display("PASS bwt_inverse_core");
        end
        else
        begin
            $display("FAIL bwt_inverse_core");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/bwti_pkg.sv
rtl/core/bwt_inverse_core.sv
bench/tb_bwt_inverse_core.sv
